/* rtl/sorted_timer_table_top_defines.svh */
// assertion macros for the sorted timer table
// used by files under rtl that carry concurrent checks
`ifndef SORTED_TIMER_TABLE_TOP_DEFINES_SVH
`define SORTED_TIMER_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define STT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STT_ASSERT(label, clk, rst_n, prop, msg)
`define STT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/stt_pkg.sv */
// shared types and constants of the sorted timer table
// no dependencies
package stt_pkg;
  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned IDENT_WIDTH_DEF = 16;
  localparam logic [15:0] CHECK_RESET = 16'd1000;
  localparam logic [31:0] DAY_SECONDS = 32'd86400;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_MOD  = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  localparam logic [1:0] KIND_ONESHOT = 2'd0;
  localparam logic [1:0] KIND_PERIOD  = 2'd1;
  localparam logic [1:0] KIND_DONCE   = 2'd2;
  localparam logic [1:0] KIND_DREP    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [1:0] status;
    logic       last;
  } res_ctl_t;
endpackage

/* rtl/sorted_timer_table_top.sv */
// top level of the sorted timer table: sequencer over entry and order memories
// depends on stt_pkg, stt_order and sorted_timer_table_top_defines.svh
//
//  port group   direction  handshake
//  in_*         input      start high while busy low takes a transaction
//  out_*        output     out_strobe marks one result a cycle, no stall
//  cfg_*        input      cfg_wr_en writes daily_check_period_ms
//
// every step reads each visited order position, then uses the registered data.
// add: insert search and shift; modify and delete: two-pass lookup, then remove
// and, for modify, insert again (a modify that misses adds a new timer). a tick
// rescans from the head after each firing, then makes a daily pass when the check
// is due. fired results leave one firing late so the final one can carry
// last_result; the receiver cannot stall. reset clears control state, slot valid
// bits, done flags and the order count; no clearing pass is needed.
`include "sorted_timer_table_top_defines.svh"
module sorted_timer_table_top #(
  parameter int unsigned TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF,
  parameter int unsigned IDENT_WIDTH = stt_pkg::IDENT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_opcode,
  input  logic [1:0]             in_timer_kind,
  input  logic [IDENT_WIDTH-1:0] in_timer_ident,
  input  logic [31:0]            in_interval_ms,
  input  logic [16:0]            in_day_second,
  input  logic [31:0]            in_now_ms,
  input  logic [16:0]            in_now_day_second,
  output logic                   out_strobe,
  output logic                   out_result_kind,
  output logic [IDENT_WIDTH-1:0] out_result_ident,
  output logic [1:0]             out_status_code,
  output logic                   out_last_result,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data
);
  localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TIMER_SLOTS);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_FIND_R = 18'h00002,  // issue order read at pos
    S_FIND_W = 18'h00004,  // read data valid, inspect
    S_DONE   = 18'h00008,  // decide after lookup
    S_RM_R   = 18'h00010,  // shift left: read pos+1
    S_RM_W   = 18'h00020,  // write pos
    S_INS_R  = 18'h00040,  // search insert point
    S_INS_W  = 18'h00080,
    S_SH_R   = 18'h00100,  // shift right: read pos-1
    S_SH_W   = 18'h00200,
    S_PUT    = 18'h00400,  // write slot at insert pos
    S_MS_R   = 18'h00800,  // tick ms scan
    S_MS_W   = 18'h01000,
    S_CHK    = 18'h02000,  // daily check due?
    S_DY_R   = 18'h04000,  // tick daily scan
    S_DY_W   = 18'h08000,
    S_FIN    = 18'h10000,  // flush held fired result
    S_EMIT   = 18'h20000   // status result
  } state_t;

  // what to do after a remove completes
  typedef enum logic [3:0] {
    AF_STATUS = 4'b0001,
    AF_INSERT = 4'b0010,
    AF_MSNEXT = 4'b0100,
    AF_DYNEXT = 4'b1000
  } after_t;

  state_t state_r;
  after_t after_r;

  // entry store held per slot (narrow depth, read at scan-selected slot)
  logic                   valid_r [TIMER_SLOTS];
  logic                   done_r  [TIMER_SLOTS];
  logic [1:0]             kind_m  [TIMER_SLOTS];
  logic [IDENT_WIDTH-1:0] ident_m [TIMER_SLOTS];
  logic [31:0]            key_m   [TIMER_SLOTS];  // deadline or day second
  logic [31:0]            per_m   [TIMER_SLOTS];

  logic [15:0]            period_r;
  logic [31:0]            chk_r;
  logic [IDENT_WIDTH-1:0] next_id_r;
  logic [CW-1:0]          cnt_r;

  logic [1:0]  op_r, tkind_r;
  logic [IDENT_WIDTH-1:0] tid_r;
  logic [31:0] ival_r, now_r;
  logic [16:0] ds_r, nds_r;

  logic [CW-1:0] pos_r, ipos_r, base_r;
  logic          pass_r, found_r;
  logic [SW-1:0] slot_r;

  // status of an operation
  logic [1:0]             stat_code_r;
  logic [IDENT_WIDTH-1:0] stat_id_r;

  // fired result held back until the next firing or the end of the tick
  logic                   hold_valid_r;
  logic [IDENT_WIDTH-1:0] hold_id_r;

  // result registers
  stt_pkg::res_ctl_t      res_r;
  logic [IDENT_WIDTH-1:0] res_id_r;

  // order memory access
  logic          o_rd_en, o_wr_en;
  logic [SW-1:0] o_rd_addr, o_wr_addr, o_wr_data, o_rd_data;

  stt_order #(.SLOTS(TIMER_SLOTS), .SW(SW)) u_order (
    .clk    (clk),
    .rd_en  (o_rd_en),
    .rd_addr(o_rd_addr),
    .rd_data(o_rd_data),
    .wr_en  (o_wr_en),
    .wr_addr(o_wr_addr),
    .wr_data(o_wr_data)
  );

  logic [SW-1:0] free_slot;
  logic          free_ok;
  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = SW'(i);
        free_ok   = 1'b1;
      end
    end
  end

  logic [16:0] ds_fix;
  assign ds_fix = (ds_r == 17'd0) ? 17'd1 : ds_r;

  // fields of the slot just read from order
  logic          rd_daily;
  logic [31:0]   rd_key;
  assign rd_daily = kind_m[o_rd_data][1];
  assign rd_key   = key_m[o_rd_data];

  logic          my_daily;
  assign my_daily = kind_m[slot_r][1];

  logic [IDENT_WIDTH-1:0] id_inc;
  assign id_inc = next_id_r + IDENT_WIDTH'(1);

  logic fire_ms, fire_dy, st_emit, fin_emit, pass_emit;
  assign fire_ms   = (state_r == S_MS_W) && !rd_daily && !done_r[o_rd_data] &&
                     (rd_key <= now_r);
  assign fire_dy   = (state_r == S_DY_W) && rd_daily && !done_r[o_rd_data] &&
                     (rd_key <= 32'(nds_r));
  assign st_emit   = (state_r == S_EMIT);
  assign fin_emit  = (state_r == S_FIN) && hold_valid_r;
  assign pass_emit = (fire_ms || fire_dy) && hold_valid_r;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    o_rd_en   = 1'b0;
    o_rd_addr = '0;
    o_wr_en   = 1'b0;
    o_wr_addr = '0;
    o_wr_data = '0;
    unique case (state_r)
      S_FIND_R, S_MS_R, S_DY_R, S_INS_R: begin
        o_rd_en   = 1'b1;
        o_rd_addr = pos_r[SW-1:0];
      end
      S_RM_R: begin
        o_rd_en   = 1'b1;
        o_rd_addr = SW'(pos_r + CW'(1));
      end
      S_SH_R: begin
        o_rd_en   = 1'b1;
        o_rd_addr = SW'(pos_r - CW'(1));
      end
      S_RM_W, S_SH_W: begin
        o_wr_en   = 1'b1;
        o_wr_addr = pos_r[SW-1:0];
        o_wr_data = o_rd_data;
      end
      S_PUT: begin
        o_wr_en   = 1'b1;
        o_wr_addr = ipos_r[SW-1:0];
        o_wr_data = slot_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      after_r      <= AF_STATUS;
      period_r     <= stt_pkg::CHECK_RESET;
      chk_r        <= 32'(stt_pkg::CHECK_RESET);
      next_id_r    <= IDENT_WIDTH'(1);
      cnt_r        <= '0;
      hold_valid_r <= 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
        done_r[i]  <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= in_opcode;
            tkind_r <= in_timer_kind;
            tid_r   <= in_timer_ident;
            ival_r  <= in_interval_ms;
            ds_r    <= in_day_second;
            now_r   <= in_now_ms;
            nds_r   <= in_now_day_second;
            pos_r   <= '0;
            pass_r  <= 1'b0;
            found_r <= 1'b0;
            if (in_opcode == stt_pkg::OP_TICK) begin
              state_r <= S_MS_R;
            end else if (in_opcode == stt_pkg::OP_ADD) begin
              state_r <= S_DONE;
            end else if (in_timer_ident == '0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_FIND_R;
            end
          end
        end
        // two-pass identifier lookup
        S_FIND_R: begin
          if (pos_r >= cnt_r) begin
            if (pass_r) begin
              state_r <= S_DONE;
            end else begin
              pass_r <= 1'b1;
              pos_r  <= '0;
            end
          end else begin
            state_r <= S_FIND_W;
          end
        end
        S_FIND_W: begin
          if (rd_daily == pass_r && ident_m[o_rd_data] == tid_r) begin
            found_r <= 1'b1;
            slot_r  <= o_rd_data;
            base_r  <= pos_r;
            state_r <= S_DONE;
          end else begin
            pos_r   <= pos_r + CW'(1);
            state_r <= S_FIND_R;
          end
        end
        S_DONE: begin
          if (op_r == stt_pkg::OP_DEL) begin
            stat_code_r <= found_r ? stt_pkg::ST_OK : stt_pkg::ST_MISS;
            stat_id_r   <= found_r ? ident_m[slot_r] : tid_r;
            if (found_r) begin
              valid_r[slot_r] <= 1'b0;
              pos_r   <= base_r;
              after_r <= AF_STATUS;
              state_r <= S_RM_R;
            end else begin
              state_r <= S_EMIT;
            end
          end else if (found_r) begin
            // retime in place, then remove and reinsert
            if (!kind_m[slot_r][1]) begin
              key_m[slot_r] <= now_r + ival_r;
              per_m[slot_r] <= ival_r;
            end else begin
              key_m[slot_r]  <= 32'(ds_fix);
              per_m[slot_r]  <= stt_pkg::DAY_SECONDS;
              done_r[slot_r] <= ds_fix < nds_r;
            end
            stat_code_r <= stt_pkg::ST_OK;
            stat_id_r   <= ident_m[slot_r];
            pos_r   <= base_r;
            after_r <= AF_INSERT;
            state_r <= S_RM_R;
          end else if (!free_ok) begin
            stat_code_r <= stt_pkg::ST_FULL;
            stat_id_r   <= '0;
            state_r     <= S_EMIT;
          end else begin
            slot_r             <= free_slot;
            valid_r[free_slot] <= 1'b1;
            kind_m[free_slot]  <= tkind_r;
            ident_m[free_slot] <= next_id_r;
            next_id_r <= (id_inc == '0) ? IDENT_WIDTH'(1) : id_inc;
            if (!tkind_r[1]) begin
              key_m[free_slot]  <= now_r + ival_r;
              per_m[free_slot]  <= ival_r;
              done_r[free_slot] <= 1'b0;
            end else begin
              key_m[free_slot]  <= 32'(ds_fix);
              per_m[free_slot]  <= stt_pkg::DAY_SECONDS;
              done_r[free_slot] <= ds_fix < nds_r;
            end
            stat_code_r <= stt_pkg::ST_OK;
            stat_id_r   <= next_id_r;
            pos_r   <= '0;
            after_r <= AF_STATUS;
            state_r <= S_INS_R;
          end
        end
        // remove entry at pos: shift tail left
        S_RM_R: begin
          if (pos_r + CW'(1) >= cnt_r) begin
            cnt_r <= cnt_r - CW'(1);
            case (after_r)
              AF_INSERT: begin
                pos_r   <= '0;
                state_r <= S_INS_R;
              end
              AF_MSNEXT: begin
                pos_r   <= '0;
                state_r <= S_MS_R;
              end
              AF_DYNEXT: begin
                pos_r   <= base_r;
                state_r <= S_DY_R;
              end
              default: state_r <= S_EMIT;
            endcase
          end else begin
            state_r <= S_RM_W;
          end
        end
        S_RM_W: begin
          pos_r   <= pos_r + CW'(1);
          state_r <= S_RM_R;
        end
        // search insert point for slot_r
        S_INS_R: begin
          if (cnt_r >= FULL_CNT) begin
            pos_r   <= '0;
            state_r <= (op_r == stt_pkg::OP_TICK) ? S_MS_R : S_EMIT;
          end else if (pos_r >= cnt_r) begin
            ipos_r  <= pos_r;
            state_r <= S_SH_R;
            pos_r   <= cnt_r;
          end else begin
            state_r <= S_INS_W;
          end
        end
        S_INS_W: begin
          if (rd_daily == my_daily && rd_key >= key_m[slot_r]) begin
            ipos_r  <= pos_r;
            pos_r   <= cnt_r;
            state_r <= S_SH_R;
          end else begin
            pos_r   <= pos_r + CW'(1);
            state_r <= S_INS_R;
          end
        end
        S_SH_R: begin
          if (pos_r <= ipos_r) begin
            state_r <= S_PUT;
          end else begin
            state_r <= S_SH_W;
          end
        end
        S_SH_W: begin
          pos_r   <= pos_r - CW'(1);
          state_r <= S_SH_R;
        end
        S_PUT: begin
          cnt_r <= cnt_r + CW'(1);
          if (op_r == stt_pkg::OP_TICK) begin
            pos_r   <= '0;
            state_r <= S_MS_R;
          end else begin
            state_r <= S_EMIT;
          end
        end
        // tick: fire the first due ms entry not yet fired, then rescan from the head
        S_MS_R: begin
          if (pos_r >= cnt_r) begin
            state_r <= S_CHK;
          end else begin
            state_r <= S_MS_W;
          end
        end
        S_MS_W: begin
          if (rd_daily || done_r[o_rd_data]) begin
            // daily entries and reloaded ones already fired this tick
            pos_r   <= pos_r + CW'(1);
            state_r <= S_MS_R;
          end else if (!fire_ms) begin
            state_r <= S_CHK;
          end else begin
            hold_valid_r <= 1'b1;
            hold_id_r    <= ident_m[o_rd_data];
            slot_r       <= o_rd_data;
            if (kind_m[o_rd_data] == stt_pkg::KIND_PERIOD) begin
              key_m[o_rd_data]  <= now_r + per_m[o_rd_data];
              done_r[o_rd_data] <= 1'b1;  // ms entry: fired-this-tick mark
              after_r <= AF_INSERT;
            end else begin
              valid_r[o_rd_data] <= 1'b0;
              after_r <= AF_MSNEXT;
            end
            state_r <= S_RM_R;
          end
        end
        S_CHK: begin
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (!kind_m[i][1]) done_r[i] <= 1'b0;
          end
          if (chk_r <= now_r) begin
            chk_r   <= now_r + 32'(period_r);
            pos_r   <= '0;
            state_r <= S_DY_R;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_DY_R: begin
          if (pos_r >= cnt_r) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_DY_W;
          end
        end
        S_DY_W: begin
          if (fire_dy && kind_m[o_rd_data] == stt_pkg::KIND_DONCE) begin
            // removal pulls the next entry into this position
            hold_valid_r       <= 1'b1;
            hold_id_r          <= ident_m[o_rd_data];
            valid_r[o_rd_data] <= 1'b0;
            base_r  <= pos_r;
            after_r <= AF_DYNEXT;
            state_r <= S_RM_R;
          end else begin
            pos_r   <= pos_r + CW'(1);
            state_r <= S_DY_R;
            if (fire_dy) begin
              hold_valid_r      <= 1'b1;
              hold_id_r         <= ident_m[o_rd_data];
              done_r[o_rd_data] <= 1'b1;
            end else if (rd_daily && rd_key > 32'(nds_r)) begin
              done_r[o_rd_data] <= 1'b0;
            end
          end
        end
        S_FIN: begin
          hold_valid_r <= 1'b0;
          state_r      <= S_IDLE;
        end
        S_EMIT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r    <= '0;
      res_id_r <= '0;
    end else begin
      res_r.valid  <= st_emit || fin_emit || pass_emit;
      res_r.kind   <= !st_emit;
      res_r.status <= st_emit ? stat_code_r : stt_pkg::ST_OK;
      res_r.last   <= st_emit || fin_emit;
      res_id_r     <= st_emit ? stat_id_r : hold_id_r;
    end
  end

  assign out_strobe       = res_r.valid;
  assign out_result_kind  = res_r.kind;
  assign out_result_ident = res_id_r;
  assign out_status_code  = res_r.status;
  assign out_last_result  = res_r.last;

  `STT_ASSERT(a_cnt_bound, clk, rst_n, (cnt_r <= FULL_CNT), "order count beyond table size")
  `STT_ASSERT(a_idle_quiet, clk, rst_n, (state_r == S_IDLE |=> !o_wr_en), "order write while idle")
  `STT_ASSERT(a_id_nonzero, clk, rst_n, (next_id_r != '0), "identifier counter reached zero")
  `STT_ASSERT_NR(a_reset_idle, clk, (!rst_n |=> !busy), "busy after reset")
endmodule

/* rtl/stt_order.sv */
// sorted order list of the timer table: a memory of slot numbers (count kept in the top)
// depends on stt_pkg; one read and one write a cycle, registered read data
module stt_order #(
  parameter int unsigned SLOTS = stt_pkg::TIMER_SLOTS_DEF,
  parameter int unsigned SW    = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output logic [SW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [SW-1:0] wr_data
);
  logic [SW-1:0] mem [SLOTS];
  logic [SW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end
  assign rd_data = rd_data_r;
endmodule
